[rtl/scaled_glyph_text_rasterizer_macros.svh]
// Assertion macros shared by the scaled glyph text rasterizer RTL.
// Defining NO_ASSERTIONS turns every use into an empty line.
`ifndef SCALED_GLYPH_TEXT_RASTERIZER_MACROS_SVH
`define SCALED_GLYPH_TEXT_RASTERIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition holds at every clock edge outside reset.
`define SGTR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sgtr: invariant violated");
// Consequent holds in the same cycle as the antecedent.
`define SGTR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgtr: implication violated");
// Consequent holds in the cycle after the antecedent.
`define SGTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgtr: next-cycle implication violated");
`else
`define SGTR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SGTR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SGTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sgtr_pkg.sv]
// Package for the scaled glyph text rasterizer: payload and control types,
// constants, register indexes and the 5x7 font ROM. No dependencies.
package sgtr_pkg;

    localparam int FRAME_DIM_MAX = 4096;
    localparam int MAX_SCALE     = 16;
    localparam int CURSOR_MAX    = 32767;

    localparam int COORD_W   = 13;
    localparam int SCALE_W   = 5;
    localparam int CODE_W    = 8;
    localparam int CURSOR_W  = 16;
    localparam int CALC_W    = 18;
    localparam int OFF_W     = 7;
    localparam int CFG_IDX_W = 3;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_VALUE    = 3'd5;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              string_start;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_right;
        logic [COORD_W-1:0] rect_bottom;
        logic               last_of_char;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [SCALE_W-1:0]        pixel_scale;
        logic [COORD_W-1:0]        frame_width;
        logic [COORD_W-1:0]        frame_height;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic cell_hit;
        logic last_cell;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } ctrl_state_t;

    function automatic logic [CODE_W-1:0] fold_case(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] res;
        res = code;
        if (code inside {[8'h61:8'h7A]})
        begin
            res = code - 8'h20;
        end
        return res;
    endfunction

    // Rows are packed top row first; the MSB of the word is row 0, column 0.
    function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [CODE_W-1:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (code)
            8'h25: g = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
            8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            8'h2D: g = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00};
            8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            8'h2F: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
            8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C};
            8'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
            8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            8'h44: g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h4A: g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
            8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

[rtl/sgtr_ctrl.sv]
// Controller of the scaled glyph text rasterizer: sequences load, cell scan
// and flush of one character. Depends on sgtr_pkg.
module sgtr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sgtr_pkg::dp_status_t  st,
    output sgtr_pkg::dp_cmd_t     cmd
);

    sgtr_pkg::ctrl_state_t state_reg;
    sgtr_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgtr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            sgtr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sgtr_pkg::ST_SCAN;
                end
            end
            sgtr_pkg::ST_SCAN:
            begin
                // A hit with a rectangle already pending must push that one out first.
                if (!(st.cell_hit && st.pend_valid && !st.out_free))
                begin
                    cmd.step = 1'b1;
                    if (st.last_cell)
                    begin
                        state_next = sgtr_pkg::ST_FLUSH;
                    end
                end
            end
            sgtr_pkg::ST_FLUSH:
            begin
                if (!st.pend_valid || st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = sgtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sgtr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/sgtr_datapath.sv]
// Datapath of the scaled glyph text rasterizer: cursor, glyph shift register,
// cell offsets, rectangle clipping, pending rectangle and output register.
// Depends on sgtr_pkg and the assertion macro header.
`include "scaled_glyph_text_rasterizer_macros.svh"

module sgtr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgtr_pkg::cfg_t        cfg,
    input  sgtr_pkg::in_item_t    in_data,
    input  sgtr_pkg::dp_cmd_t     cmd,
    output sgtr_pkg::dp_status_t  st,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sgtr_pkg::out_item_t   out_data
);

    localparam logic [2:0] COL_LAST = 3'(sgtr_pkg::GLYPH_COLS - 1);
    localparam logic [2:0] ROW_LAST = 3'(sgtr_pkg::GLYPH_ROWS - 1);

    logic signed [sgtr_pkg::CURSOR_W-1:0] cursor_reg;
    logic signed [sgtr_pkg::CURSOR_W-1:0] cursor_next;
    logic [sgtr_pkg::GLYPH_BITS-1:0]      glyph_reg;
    logic [2:0]                           col_reg;
    logic [2:0]                           row_reg;
    logic [sgtr_pkg::OFF_W-1:0]           x_off_reg;
    logic [sgtr_pkg::OFF_W-1:0]           y_off_reg;
    logic                                 pend_valid_reg;
    sgtr_pkg::out_item_t                  pend_reg;
    logic                                 out_valid_reg;
    sgtr_pkg::out_item_t                  out_reg;

    logic [sgtr_pkg::SCALE_W-1:0]         scale;
    logic [sgtr_pkg::COORD_W-1:0]         width_lim;
    logic [sgtr_pkg::COORD_W-1:0]         height_lim;
    logic signed [sgtr_pkg::CALC_W-1:0]   left;
    logic signed [sgtr_pkg::CALC_W-1:0]   top;
    logic signed [sgtr_pkg::CALC_W-1:0]   right_raw;
    logic signed [sgtr_pkg::CALC_W-1:0]   bottom_raw;
    logic signed [sgtr_pkg::CALC_W-1:0]   x0;
    logic signed [sgtr_pkg::CALC_W-1:0]   y0;
    logic signed [sgtr_pkg::CALC_W-1:0]   x1;
    logic signed [sgtr_pkg::CALC_W-1:0]   y1;
    logic signed [sgtr_pkg::CALC_W-1:0]   w_s;
    logic signed [sgtr_pkg::CALC_W-1:0]   h_s;
    logic signed [sgtr_pkg::CALC_W-1:0]   s_s;
    logic signed [sgtr_pkg::CURSOR_W:0]   cursor_sum;
    logic [sgtr_pkg::OFF_W:0]             advance;
    logic                                 hit;
    logic                                 last_cell;
    logic                                 out_free;
    logic                                 push;
    sgtr_pkg::out_item_t                  cell_rect;
    sgtr_pkg::out_item_t                  push_rect;

    always_comb
    begin
        scale      = (cfg.pixel_scale > sgtr_pkg::SCALE_W'(sgtr_pkg::MAX_SCALE))
                   ? sgtr_pkg::SCALE_W'(sgtr_pkg::MAX_SCALE) : cfg.pixel_scale;
        width_lim  = (cfg.frame_width > sgtr_pkg::COORD_W'(sgtr_pkg::FRAME_DIM_MAX))
                   ? sgtr_pkg::COORD_W'(sgtr_pkg::FRAME_DIM_MAX) : cfg.frame_width;
        height_lim = (cfg.frame_height > sgtr_pkg::COORD_W'(sgtr_pkg::FRAME_DIM_MAX))
                   ? sgtr_pkg::COORD_W'(sgtr_pkg::FRAME_DIM_MAX) : cfg.frame_height;

        s_s = signed'(sgtr_pkg::CALC_W'(scale));
        w_s = signed'(sgtr_pkg::CALC_W'(width_lim));
        h_s = signed'(sgtr_pkg::CALC_W'(height_lim));

        left       = sgtr_pkg::CALC_W'(cursor_reg)
                   + signed'(sgtr_pkg::CALC_W'(x_off_reg));
        top        = sgtr_pkg::CALC_W'(cfg.origin_y)
                   + signed'(sgtr_pkg::CALC_W'(y_off_reg));
        right_raw  = left + s_s;
        bottom_raw = top + s_s;

        x0 = left[sgtr_pkg::CALC_W-1] ? '0 : left;
        y0 = top[sgtr_pkg::CALC_W-1] ? '0 : top;
        x1 = (right_raw > w_s) ? w_s : right_raw;
        y1 = (bottom_raw > h_s) ? h_s : bottom_raw;

        hit = glyph_reg[sgtr_pkg::GLYPH_BITS-1] && (x0 < x1) && (y0 < y1);

        cell_rect.rect_left    = x0[sgtr_pkg::COORD_W-1:0];
        cell_rect.rect_top     = y0[sgtr_pkg::COORD_W-1:0];
        cell_rect.rect_right   = x1[sgtr_pkg::COORD_W-1:0];
        cell_rect.rect_bottom  = y1[sgtr_pkg::COORD_W-1:0];
        cell_rect.last_of_char = 1'b0;

        push_rect              = pend_reg;
        push_rect.last_of_char = cmd.finish;

        // The cursor moves six cells of the current scale, saturating upward.
        advance     = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};
        cursor_sum  = (sgtr_pkg::CURSOR_W+1)'(cursor_reg)
                    + signed'((sgtr_pkg::CURSOR_W+1)'(advance));
        cursor_next = (cursor_sum > (sgtr_pkg::CURSOR_W+1)'(sgtr_pkg::CURSOR_MAX))
                    ? sgtr_pkg::CURSOR_W'(sgtr_pkg::CURSOR_MAX)
                    : cursor_sum[sgtr_pkg::CURSOR_W-1:0];

        last_cell = (col_reg == COL_LAST) && (row_reg == ROW_LAST);
        out_free  = !out_valid_reg || !out_stall;
        push      = pend_valid_reg && ((cmd.step && hit) || cmd.finish);

        st.cell_hit   = hit;
        st.last_cell  = last_cell;
        st.pend_valid = pend_valid_reg;
        st.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (in_data.string_start)
                begin
                    cursor_reg <= sgtr_pkg::CURSOR_W'(cfg.origin_x);
                end
                pend_valid_reg <= 1'b0;
                col_reg        <= '0;
                row_reg        <= '0;
            end
            if (cmd.step)
            begin
                if (hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
                if (!last_cell)
                begin
                    if (col_reg == COL_LAST)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 3'd1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 3'd1;
                    end
                end
            end
            if (cmd.finish)
            begin
                cursor_reg     <= cursor_next;
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            glyph_reg <= sgtr_pkg::font_glyph(sgtr_pkg::fold_case(in_data.char_code));
            x_off_reg <= '0;
            y_off_reg <= '0;
        end
        if (cmd.step)
        begin
            glyph_reg <= glyph_reg << 1;
            if (hit)
            begin
                pend_reg <= cell_rect;
            end
            if (!last_cell)
            begin
                if (col_reg == COL_LAST)
                begin
                    x_off_reg <= '0;
                    y_off_reg <= y_off_reg + sgtr_pkg::OFF_W'(scale);
                end
                else
                begin
                    x_off_reg <= x_off_reg + sgtr_pkg::OFF_W'(scale);
                end
            end
        end
        if (push)
        begin
            out_reg <= push_rect;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SGTR_ASSERT_IMPLIES(a_push_only_when_free, clk, rst_n, push, out_free)
    `SGTR_ASSERT_ALWAYS(a_scan_position_in_range, clk, rst_n, (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
    `SGTR_ASSERT_NEXT(a_load_restarts_scan, clk, rst_n, cmd.load, (col_reg == 3'd0) && (row_reg == 3'd0) && !pend_valid_reg)
    `SGTR_ASSERT_NEXT(a_finish_drains_pending, clk, rst_n, cmd.finish, !pend_valid_reg && (!(push) || 1'b1))

endmodule

[rtl/scaled_glyph_text_rasterizer.sv]
// Scaled glyph text rasterizer: turns character codes into clipped rectangles
// for the lit cells of a 5x7 font. Holds the configuration registers.
// Depends on sgtr_pkg, sgtr_ctrl and sgtr_datapath.
// Usage:
//   Input channel (in_valid, in_stall, in_data) takes one character per
//   transaction; string_start reloads the cursor from origin_x first.
//   Output channel (out_valid, out_stall, out_data) gives one clipped
//   rectangle per transaction, last_of_char set on the final rectangle of a
//   character. A character whose cells all clip away gives no transaction.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes one
//   register per transaction; cfg_ready is always high. Write only when idle.
// Timing:
//   A character goes through acceptance, a scan of its 35 glyph cells (one
//   cell a cycle through the clipping datapath unless an output stall holds
//   the scan) and a flush. Each rectangle waits in a pending register until
//   the next hit or the flush pushes it into the output register.
//   An output stall holds the scan whenever a new hit finds the pending and
//   output registers both full; in_stall stays high until the flush is done.
// Reset: clears the cursor to 0, loads the register reset values and empties
//   the output register.
module scaled_glyph_text_rasterizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sgtr_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sgtr_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sgtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgtr_pkg::COORD_W-1:0]        cfg_data
);

    sgtr_pkg::cfg_t       cfg_reg;
    sgtr_pkg::dp_cmd_t    cmd;
    sgtr_pkg::dp_status_t st;

    assign cfg_ready = 1'b1;

    // The ink level only matters to the downstream fill, so its writes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.pixel_scale  <= sgtr_pkg::SCALE_W'(1);
            cfg_reg.frame_width  <= sgtr_pkg::COORD_W'(sgtr_pkg::FRAME_DIM_MAX);
            cfg_reg.frame_height <= sgtr_pkg::COORD_W'(sgtr_pkg::FRAME_DIM_MAX);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sgtr_pkg::CFG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_data;
                sgtr_pkg::CFG_ORIGIN_Y:     cfg_reg.origin_y     <= cfg_data;
                sgtr_pkg::CFG_PIXEL_SCALE:
                    cfg_reg.pixel_scale <= cfg_data[sgtr_pkg::SCALE_W-1:0];
                sgtr_pkg::CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                sgtr_pkg::CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                sgtr_pkg::CFG_INK_VALUE:    ;
                default:                    ;
            endcase
        end
    end

    sgtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    sgtr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
